FILE: design/sthg_pkg.sv
package sthg_pkg;

    // APB register map, one 32-bit register every four bytes.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SERVO_CENTER    = 3'd0;
    localparam logic [2:0] REG_HOLD_TIMEOUT_US = 3'd1;
    localparam logic [2:0] REG_MIN_TURN_OFFSET = 3'd2;
    localparam logic [2:0] REG_RETRACT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_EXIT_FRAMES     = 3'd4;

    localparam logic [11:0] SERVO_CENTER_RST    = 12'd1445;
    localparam logic [31:0] HOLD_TIMEOUT_US_RST = 32'd300000;
    localparam logic [11:0] MIN_TURN_OFFSET_RST = 12'd30;
    localparam logic [11:0] RETRACT_LIMIT_RST   = 12'd80;
    localparam logic [7:0]  EXIT_FRAMES_RST     = 8'd3;

    // Steering modes that turn; every other mode is straight.
    localparam logic [3:0] MODE_RIGHT_SOFT = 4'd1;
    localparam logic [3:0] MODE_LEFT_SOFT  = 4'd2;
    localparam logic [3:0] MODE_RIGHT_HARD = 4'd3;
    localparam logic [3:0] MODE_LEFT_HARD  = 4'd4;
    localparam logic [3:0] MODE_RIGHT_MID  = 4'd8;
    localparam logic [3:0] MODE_LEFT_MID   = 4'd9;

    localparam logic [1:0] RANK_LOW  = 2'd1;
    localparam logic [1:0] RANK_MID  = 2'd2;
    localparam logic [1:0] RANK_HIGH = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        SIDE_NONE,
        SIDE_RIGHT,
        SIDE_LEFT
    } side_t;

    typedef struct packed {
        logic        active;
        logic [31:0] stamp;
        logic [3:0]  mode;
        logic [11:0] pwm;
        logic [7:0]  count;
    } anchor_t;

    typedef struct packed {
        logic [11:0] center;
        logic [31:0] timeout;
        logic [11:0] min_offset;
        logic [11:0] retract;
        logic [7:0]  exit_frames;
    } guard_cfg_t;

    function automatic side_t side_of(input logic [3:0] mode);
        side_t s;
        unique case (mode)
            MODE_RIGHT_SOFT, MODE_RIGHT_HARD, MODE_RIGHT_MID: s = SIDE_RIGHT;
            MODE_LEFT_SOFT, MODE_LEFT_HARD, MODE_LEFT_MID:    s = SIDE_LEFT;
            default:                                          s = SIDE_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] rank_of(input logic [3:0] mode);
        logic [1:0] r;
        unique case (mode)
            MODE_RIGHT_HARD, MODE_LEFT_HARD: r = RANK_HIGH;
            MODE_RIGHT_MID, MODE_LEFT_MID:   r = RANK_MID;
            default:                         r = RANK_LOW;
        endcase
        return r;
    endfunction

    // Signed distance of a PWM value from center, measured in the turn direction.
    function automatic logic signed [12:0] offset_of(input side_t side,
                                                     input logic [11:0] center,
                                                     input logic [11:0] pwm);
        logic signed [12:0] c;
        logic signed [12:0] p;
        c = $signed({1'b0, center});
        p = $signed({1'b0, pwm});
        return (side == SIDE_RIGHT) ? (c - p) : (p - c);
    endfunction

endpackage

FILE: design/sthg_decide.sv
module sthg_decide (
    input  sthg_pkg::guard_cfg_t cfg,
    input  sthg_pkg::anchor_t    state,
    input  logic [3:0]           frame_mode,
    input  logic                 frame_valid,
    input  logic                 looks_straight,
    input  logic [11:0]          proposed_pwm,
    input  logic [31:0]          time_us,
    output sthg_pkg::anchor_t    state_next,
    output logic [11:0]          servo_pwm,
    output logic                 was_held
);
    import sthg_pkg::*;

    always_comb
    begin
        anchor_t            st;
        side_t              side;
        logic [31:0]        elapsed;
        logic signed [12:0] off;
        logic signed [12:0] prev;
        logic signed [13:0] pullback;
        logic               same;
        logic               weaker;
        logic               retracted;

        st        = state;
        side      = side_of(frame_mode);
        elapsed   = time_us - state.stamp;
        off       = offset_of(side, cfg.center, proposed_pwm);
        prev      = offset_of(side, cfg.center, state.pwm);
        pullback  = {prev[12], prev} - {off[12], off};
        servo_pwm = proposed_pwm;
        was_held  = 1'b0;

        // Expiry is applied before anything else looks at the anchor.
        if (st.active && (elapsed >= cfg.timeout))
        begin
            st.active = 1'b0;
            st.count  = '0;
        end

        same      = st.active && (side == side_of(st.mode));
        weaker    = (rank_of(frame_mode) < rank_of(st.mode)) && (off < prev);
        retracted = pullback > $signed({2'b00, cfg.retract});

        priority if (!frame_valid)
        begin
            st.count = '0;
        end
        else if (side != SIDE_NONE)
        begin
            st.count = '0;
            priority if (off < $signed({1'b0, cfg.min_offset}))
            begin
                if (same)
                begin
                    was_held  = 1'b1;
                    servo_pwm = st.pwm;
                end
                else
                begin
                    st.active = 1'b0;
                end
            end
            else if (same && (weaker || retracted))
            begin
                was_held  = 1'b1;
                servo_pwm = st.pwm;
            end
            else
            begin
                st.active = 1'b1;
                st.mode   = frame_mode;
                st.pwm    = proposed_pwm;
                st.stamp  = time_us;
            end
        end
        else if (st.active)
        begin
            if (looks_straight)
                st.count = (st.count == COUNT_MAX) ? COUNT_MAX : st.count + 8'd1;
            else
                st.count = '0;
            if (st.count >= cfg.exit_frames)
            begin
                st.active = 1'b0;
                st.count  = '0;
            end
            else
            begin
                was_held  = 1'b1;
                servo_pwm = st.pwm;
            end
        end
        else
        begin
            // A straight frame with no anchor leaves the count as it stands,
            // including the clear from an expiry above.
        end

        state_next = st;
    end

endmodule

FILE: design/steering_turn_hold_guard.sv
// Steering turn hold guard.
// Input channel (in_valid / in_stall) carries one steering frame per word:
// frame_mode, frame_valid, looks_straight, proposed_pwm and time_us. The
// output channel (out_valid / out_stall) returns one word per frame with the
// PWM to drive and a flag telling whether the latched turn anchor replaced
// the proposed value.
// A frame taken at one edge lands in the input register; the decision and
// the anchor update happen when it moves on, at the edge that also loads the
// result register, which a receiver stall can delay. out_valid rises when the
// result register is loaded, and one frame is accepted every cycle while the output
// is not stalled; the anchor and straight counter, which each frame reads and rewrites, are updated at that edge.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more frame; in_stall rises only when both are
// full and the output is stalled.
// Reset clears the anchor and counter, empties both registers and loads the
// configuration registers with their defaults. Registers are to be written over
// the APB port only while no frame is in flight; the block does not enforce it.
module steering_turn_hold_guard (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sthg_pkg::ADDR_W-1:0]  paddr,
    input  logic [sthg_pkg::DATA_W-1:0]  pwdata,
    output logic [sthg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [3:0]                   frame_mode,
    input  logic                         frame_valid,
    input  logic                         looks_straight,
    input  logic [11:0]                  proposed_pwm,
    input  logic [31:0]                  time_us,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [11:0]                  servo_pwm,
    output logic                         was_held
);
    import sthg_pkg::*;

    guard_cfg_t  cfg_reg;
    anchor_t     anchor_reg;
    anchor_t     anchor_next;
    logic        s1_valid_reg;
    logic [3:0]  s1_mode_reg;
    logic        s1_frame_valid_reg;
    logic        s1_straight_reg;
    logic [11:0] s1_pwm_reg;
    logic [31:0] s1_time_reg;
    logic        out_valid_reg;
    logic [11:0] out_pwm_reg;
    logic        out_held_reg;
    logic [11:0] dec_pwm;
    logic        dec_held;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic        out_free;
    logic        s1_take;
    logic        s1_move;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center      <= SERVO_CENTER_RST;
            cfg_reg.timeout     <= HOLD_TIMEOUT_US_RST;
            cfg_reg.min_offset  <= MIN_TURN_OFFSET_RST;
            cfg_reg.retract     <= RETRACT_LIMIT_RST;
            cfg_reg.exit_frames <= EXIT_FRAMES_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SERVO_CENTER:    cfg_reg.center      <= pwdata[11:0];
                REG_HOLD_TIMEOUT_US: cfg_reg.timeout     <= pwdata[31:0];
                REG_MIN_TURN_OFFSET: cfg_reg.min_offset  <= pwdata[11:0];
                REG_RETRACT_LIMIT:   cfg_reg.retract     <= pwdata[11:0];
                REG_EXIT_FRAMES:     cfg_reg.exit_frames <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SERVO_CENTER:    prdata = {20'd0, cfg_reg.center};
            REG_HOLD_TIMEOUT_US: prdata = cfg_reg.timeout;
            REG_MIN_TURN_OFFSET: prdata = {20'd0, cfg_reg.min_offset};
            REG_RETRACT_LIMIT:   prdata = {20'd0, cfg_reg.retract};
            REG_EXIT_FRAMES:     prdata = {24'd0, cfg_reg.exit_frames};
            default:             prdata = '0;
        endcase
    end

    // The result register frees up when empty or when its word is taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign s1_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_mode_reg        <= frame_mode;
            s1_frame_valid_reg <= frame_valid;
            s1_straight_reg    <= looks_straight;
            s1_pwm_reg         <= proposed_pwm;
            s1_time_reg        <= time_us;
        end
    end

    sthg_decide u_decide (
        .cfg            (cfg_reg),
        .state          (anchor_reg),
        .frame_mode     (s1_mode_reg),
        .frame_valid    (s1_frame_valid_reg),
        .looks_straight (s1_straight_reg),
        .proposed_pwm   (s1_pwm_reg),
        .time_us        (s1_time_reg),
        .state_next     (anchor_next),
        .servo_pwm      (dec_pwm),
        .was_held       (dec_held)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            anchor_reg <= '0;
        else if (s1_move)
            anchor_reg <= anchor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pwm_reg  <= dec_pwm;
            out_held_reg <= dec_held;
        end
    end

    assign out_valid = out_valid_reg;
    assign servo_pwm = out_pwm_reg;
    assign was_held  = out_held_reg;

    // A held result always carries the anchor value that stays latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (!was_held || (servo_pwm == anchor_reg.pwm)))
        else $error("held result differs from anchor pwm");

    // The straight counter only runs while an anchor is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        !anchor_reg.active |-> (anchor_reg.count == '0))
        else $error("straight counter nonzero without anchor");

    // Backpressure reaches the input only when both registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with free space");

    // The anchor changes only when a frame is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(anchor_reg))
        else $error("anchor changed without a frame");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sthg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_ROWS      = 25;

    // Modes that do not turn; the package only names the turning ones.
    localparam logic [3:0] MODE_STRAIGHT_A = 4'd0;
    localparam logic [3:0] MODE_STRAIGHT_B = 4'd15;
    localparam logic [3:0] MODE_STRAIGHT_C = 4'd7;
    localparam logic [3:0] MODE_STRAIGHT_D = 4'd12;

    typedef struct {
        logic [3:0]  mode;
        logic        fvalid;
        logic        straight;
        logic [11:0] pwm;
        logic [31:0] stamp;
        bit          pinned;
        logic [11:0] want_pwm;
        logic        want_held;
    } frame_row_t;

    typedef struct {
        logic [11:0] pwm;
        logic        held;
    } steer_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [3:0]          frame_mode = '0;
    logic                frame_valid = 1'b0;
    logic                looks_straight = 1'b0;
    logic [11:0]         proposed_pwm = '0;
    logic [31:0]         time_us = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [11:0]         servo_pwm;
    logic                was_held;

    // Typed-in expectation that travels with a directed word.
    logic                row_pinned = 1'b0;
    logic [11:0]         row_pwm = '0;
    logic                row_held = 1'b0;

    // Shadow of the guard: configuration and the latched turn anchor.
    guard_cfg_t          cfg_shadow = '{SERVO_CENTER_RST, HOLD_TIMEOUT_US_RST,
                                        MIN_TURN_OFFSET_RST, RETRACT_LIMIT_RST,
                                        EXIT_FRAMES_RST};
    bit                  hold_active = 1'b0;
    logic [31:0]         hold_stamp = '0;
    logic [3:0]          hold_mode = '0;
    logic [11:0]         hold_pwm = '0;
    logic [7:0]          straight_run = '0;

    steer_word_t         steer_expected[$];
    int                  err_count = 0;
    int                  cycles = 0;
    int                  burst_left = 0;
    int                  stall_left = 0;
    int                  stall_kind = 0;
    logic [31:0]         now_us = 32'h0000_1000;

    frame_row_t frame_rows [N_ROWS] = '{
        '{MODE_STRAIGHT_A, 1'b1, 1'b0, 12'd0,    32'd0,         1'b1, 12'd0,    1'b0},
        '{MODE_STRAIGHT_B, 1'b0, 1'b1, 12'd4095, 32'hFFFF_FFFF, 1'b1, 12'd4095, 1'b0},
        '{MODE_RIGHT_SOFT, 1'b1, 1'b0, 12'd1300, 32'd1000,      1'b1, 12'd1300, 1'b0},
        '{MODE_STRAIGHT_A, 1'b1, 1'b1, 12'd1445, 32'd2000,      1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_C, 1'b1, 1'b1, 12'd1500, 32'd3000,      1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_D, 1'b1, 1'b1, 12'd1460, 32'd3500,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_HARD,  1'b1, 1'b0, 12'd1700, 32'd4000,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_SOFT,  1'b1, 1'b0, 12'd1600, 32'd4500,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_MID,   1'b1, 1'b0, 12'd1560, 32'd5000,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_HARD,  1'b1, 1'b0, 12'd1650, 32'd5500,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_HARD,  1'b1, 1'b0, 12'd1550, 32'd6000,      1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_SOFT,  1'b1, 1'b0, 12'd1460, 32'd6500,      1'b0, 12'd0,    1'b0},
        '{MODE_RIGHT_HARD, 1'b1, 1'b0, 12'd1200, 32'd10000,     1'b0, 12'd0,    1'b0},
        '{MODE_RIGHT_MID,  1'b1, 1'b0, 12'd1445, 32'd11000,     1'b0, 12'd0,    1'b0},
        '{MODE_RIGHT_SOFT, 1'b1, 1'b0, 12'd4095, 32'd12000,     1'b1, 12'd1200, 1'b1},
        '{MODE_LEFT_SOFT,  1'b1, 1'b0, 12'd0,    32'd13000,     1'b1, 12'd0,    1'b0},
        '{MODE_STRAIGHT_A, 1'b1, 1'b1, 12'd2048, 32'd14000,     1'b0, 12'd0,    1'b0},
        '{MODE_RIGHT_MID,  1'b1, 1'b0, 12'd1000, 32'd20000,     1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_A, 1'b1, 1'b1, 12'd1445, 32'd320000,    1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_MID,   1'b1, 1'b0, 12'd2000, 32'hFFFF_FF00, 1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_A, 1'b1, 1'b0, 12'd100,  32'h0000_0100, 1'b0, 12'd0,    1'b0},
        '{MODE_LEFT_MID,   1'b0, 1'b0, 12'd333,  32'h0000_0150, 1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_C, 1'b1, 1'b1, 12'd4095, 32'h0000_0200, 1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_B, 1'b1, 1'b1, 12'd1445, 32'h0000_0300, 1'b0, 12'd0,    1'b0},
        '{MODE_STRAIGHT_D, 1'b1, 1'b1, 12'd1445, 32'h0000_0400, 1'b0, 12'd0,    1'b0}
    };

    steering_turn_hold_guard i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_mode     (frame_mode),
        .frame_valid    (frame_valid),
        .looks_straight (looks_straight),
        .proposed_pwm   (proposed_pwm),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .servo_pwm      (servo_pwm),
        .was_held       (was_held)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic side_t turn_side(input logic [3:0] mode);
        case (mode)
            MODE_RIGHT_SOFT, MODE_RIGHT_HARD, MODE_RIGHT_MID: return SIDE_RIGHT;
            MODE_LEFT_SOFT, MODE_LEFT_HARD, MODE_LEFT_MID:    return SIDE_LEFT;
            default:                                          return SIDE_NONE;
        endcase
    endfunction

    function automatic int mode_strength(input logic [3:0] mode);
        case (mode)
            MODE_RIGHT_HARD, MODE_LEFT_HARD: return RANK_HIGH;
            MODE_RIGHT_MID, MODE_LEFT_MID:   return RANK_MID;
            default:                         return RANK_LOW;
        endcase
    endfunction

    // How far a PWM value leans from center in the given turn direction.
    function automatic int lean_of(input side_t side, input logic [11:0] pwm);
        int c;
        int q;
        c = cfg_shadow.center;
        q = pwm;
        return (side == SIDE_RIGHT) ? (c - q) : (q - c);
    endfunction

    task automatic guard_step(input logic [3:0] mode, input logic fvalid,
                              input logic straight, input logic [11:0] pwm,
                              input logic [31:0] now, output logic [11:0] out_pwm,
                              output logic out_held);
        side_t       side;
        int          lean;
        int          prev_lean;
        bit          same;
        logic [31:0] elapsed;
        side = turn_side(mode);
        out_pwm = pwm;
        out_held = 1'b0;
        elapsed = now - hold_stamp;
        if (hold_active && elapsed >= cfg_shadow.timeout)
        begin
            hold_active = 1'b0;
            straight_run = '0;
        end
        if (!fvalid)
        begin
            straight_run = '0;
        end
        else if (side != SIDE_NONE)
        begin
            lean = lean_of(side, pwm);
            prev_lean = lean_of(side, hold_pwm);
            same = hold_active && (side == turn_side(hold_mode));
            straight_run = '0;
            if (lean < int'(cfg_shadow.min_offset))
            begin
                if (same)
                begin
                    out_held = 1'b1;
                    out_pwm = hold_pwm;
                end
                else
                begin
                    hold_active = 1'b0;
                end
            end
            else if (same && ((mode_strength(mode) < mode_strength(hold_mode)
                               && lean < prev_lean)
                              || (prev_lean - lean > int'(cfg_shadow.retract))))
            begin
                out_held = 1'b1;
                out_pwm = hold_pwm;
            end
            else
            begin
                hold_active = 1'b1;
                hold_mode = mode;
                hold_pwm = pwm;
                hold_stamp = now;
            end
        end
        else if (hold_active)
        begin
            if (straight)
                straight_run = (straight_run == COUNT_MAX) ? COUNT_MAX : straight_run + 8'd1;
            else
                straight_run = '0;
            if (straight_run >= cfg_shadow.exit_frames)
            begin
                hold_active = 1'b0;
                straight_run = '0;
            end
            else
            begin
                out_held = 1'b1;
                out_pwm = hold_pwm;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Output side is checked before the input side predicts, all on pre-edge values.
    always @(posedge clk)
    begin : watch
        steer_word_t want;
        logic [11:0] p;
        logic        h;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (steer_expected.size() == 0)
                begin
                    report_mismatch("word with none expected, servo_pwm", 32'(servo_pwm),
                                    32'd0);
                end
                else
                begin
                    want = steer_expected.pop_front();
                    if (servo_pwm !== want.pwm)
                        report_mismatch("servo_pwm", 32'(servo_pwm), 32'(want.pwm));
                    if (was_held !== want.held)
                        report_mismatch("was_held", 32'(was_held), 32'(want.held));
                end
            end
            if (in_valid && !in_stall)
            begin
                guard_step(frame_mode, frame_valid, looks_straight, proposed_pwm, time_us,
                           p, h);
                if (row_pinned)
                    steer_expected.push_back('{row_pwm, row_held});
                else
                    steer_expected.push_back('{p, h});
            end
        end
    end

    // Receiver stall: stretches of free flow, light and heavy random stall, and long runs.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 16) < 11;
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SERVO_CENTER:    cfg_shadow.center = value[11:0];
            REG_HOLD_TIMEOUT_US: cfg_shadow.timeout = value;
            REG_MIN_TURN_OFFSET: cfg_shadow.min_offset = value[11:0];
            REG_RETRACT_LIMIT:   cfg_shadow.retract = value[11:0];
            REG_EXIT_FRAMES:     cfg_shadow.exit_frames = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_guard(input logic [11:0] center, input logic [31:0] timeout,
                             input logic [11:0] min_offset, input logic [11:0] retract,
                             input logic [7:0] exit_frames);
        write_reg(REG_SERVO_CENTER, {20'd0, center});
        write_reg(REG_HOLD_TIMEOUT_US, timeout);
        write_reg(REG_MIN_TURN_OFFSET, {20'd0, min_offset});
        write_reg(REG_RETRACT_LIMIT, {20'd0, retract});
        write_reg(REG_EXIT_FRAMES, {24'd0, exit_frames});
    endtask

    // Sender works in bursts; a gap, if any, opens each burst.
    task automatic send_frame(input logic [3:0] mode, input logic fvalid,
                              input logic straight, input logic [11:0] pwm,
                              input logic [31:0] stamp, input bit pinned,
                              input logic [11:0] want_pwm, input logic want_held);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        frame_mode <= mode;
        frame_valid <= fvalid;
        looks_straight <= straight;
        proposed_pwm <= pwm;
        time_us <= stamp;
        row_pinned <= pinned;
        row_pwm <= want_pwm;
        row_held <= want_held;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop sending and let every expected word come back before touching registers.
    // The first edge lets the watcher record the last accepted word.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (steer_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [3:0] pick_turn_mode();
        case ($urandom_range(0, 5))
            0:       return MODE_RIGHT_SOFT;
            1:       return MODE_RIGHT_HARD;
            2:       return MODE_RIGHT_MID;
            3:       return MODE_LEFT_SOFT;
            4:       return MODE_LEFT_HARD;
            default: return MODE_LEFT_MID;
        endcase
    endfunction

    // Mostly plausible steering: turn modes leaning the right way around center,
    // time moving forward, with some wild PWM values and time jumps mixed in.
    task automatic random_frames(input int count);
        logic [3:0] mode;
        side_t      side;
        int         delta;
        int         p;
        repeat (count)
        begin
            mode = ($urandom_range(0, 4) < 3) ? pick_turn_mode() : 4'($urandom_range(0, 15));
            side = turn_side(mode);
            delta = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 700))
                                                : -int'($urandom_range(0, 100));
            p = cfg_shadow.center;
            p = (side == SIDE_RIGHT) ? p - delta : p + delta;
            if ($urandom_range(0, 6) == 0)
                p = $urandom_range(0, 4095);
            if (p < 0)
                p = 0;
            if (p > 4095)
                p = 4095;
            case ($urandom_range(0, 9))
                0:       now_us = $urandom;
                1:       now_us = now_us + $urandom_range(0, 400000);
                default: now_us = now_us + $urandom_range(0, 3000);
            endcase
            send_frame(mode, $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0,
                       p[11:0], now_us, 1'b0, 12'd0, 1'b0);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_frame(frame_rows[i].mode, frame_rows[i].fvalid, frame_rows[i].straight,
                       frame_rows[i].pwm, frame_rows[i].stamp, frame_rows[i].pinned,
                       frame_rows[i].want_pwm, frame_rows[i].want_held);

        drain();
        set_guard(12'd2048, 32'd5000, 12'd0, 12'd0, 8'd1);
        random_frames(170);

        drain();
        set_guard(12'd0, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 8'd255);
        random_frames(170);

        drain();
        set_guard(12'd4095, 32'd0, 12'd10, 12'd40, 8'd2);
        random_frames(170);

        drain();
        set_guard(12'($urandom_range(1000, 3000)), $urandom_range(1000, 400000),
                  12'($urandom_range(0, 200)), 12'($urandom_range(0, 300)),
                  8'($urandom_range(1, 8)));
        random_frames(170);

        // Back to the defaults; a held anchor may carry over with a lower exit count.
        drain();
        set_guard(SERVO_CENTER_RST, HOLD_TIMEOUT_US_RST, MIN_TURN_OFFSET_RST,
                  RETRACT_LIMIT_RST, EXIT_FRAMES_RST);
        random_frames(170);

        drain();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
